@@ rtl/core/wsf_pkg.sv @@
package wsf_pkg;

    localparam int HASH_W = 64;
    localparam int BYTE_W = 8;
    localparam int WIN_W  = 5;

    localparam int MAX_WINDOW_DEF = 20;
    localparam int WINDOW_MIN     = 2;
    localparam int WINDOW_RESET   = 5;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    // prime is 2^40 + 0x1b3, so the multiply is a handful of shifted adds
    function automatic logic [HASH_W-1:0] fnv_step(
        input logic [HASH_W-1:0] acc,
        input logic [HASH_W-1:0] val
    );
        logic [HASH_W-1:0] x;
        x = acc ^ val;
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

    function automatic logic is_separator(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

@@ rtl/core/wsf_ring.sv @@
module wsf_ring #(
    parameter int DEPTH = 20
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic [wsf_pkg::HASH_W-1:0]   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [wsf_pkg::HASH_W-1:0]   o_rd_data
);
    import wsf_pkg::*;

    logic [HASH_W-1:0] r_mem [DEPTH];
    logic [HASH_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/word_shingle_fnv1a_fingerprint.sv @@
// channel    | direction | handshake                  | payload
// -----------+-----------+----------------------------+-----------------------------------------
// text in    | input     | i_in_valid / o_in_stall    | i_text_byte, i_end_of_text
// result out | output    | o_out_valid / i_out_stall  | o_fingerprint, o_fingerprint_valid,
//            |           |                            | o_last_result
// config     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata (window_words @ 0)
//
// a byte inside a word or between words is taken in S_IDLE without leaving it
// a word end goes to S_CLOSE to push the word hash into the ring memory, then, with a full
// window, to S_COMB for the combine (one ring read and one fnv step per word, issued
// in turn through the single read port of the ring), then to S_EMIT to load the result
// an end-of-text byte that closes no word goes straight to S_EMIT (marker result)
// reset is synchronous and active low; the ring memory is not cleared, only written
// entries are ever read; a stalled result stays in the output register while
// the next text bytes are still taken in

module word_shingle_fnv1a_fingerprint #(
    parameter int MAX_WINDOW = wsf_pkg::MAX_WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // text in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [wsf_pkg::BYTE_W-1:0]    i_text_byte,
    input  logic                          i_end_of_text,
    // result out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wsf_pkg::HASH_W-1:0]    o_fingerprint,
    output logic                          o_fingerprint_valid,
    output logic                          o_last_result,
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import wsf_pkg::*;

    localparam int SLOT_W  = $clog2(MAX_WINDOW);
    localparam int SEEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = ($clog2(2 * MAX_WINDOW) > WIN_W) ? $clog2(2 * MAX_WINDOW)
                                                               : WIN_W + 1;
    localparam logic [0:0] REG_WINDOW = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLOSE,
        S_COMB,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [WIN_W-1:0]  r_window;
    logic [HASH_W-1:0] r_word_hash;
    logic              r_in_word;
    logic [SLOT_W-1:0] r_slot;
    logic [SEEN_W-1:0] r_seen;
    logic              r_last;
    logic              r_fp_valid;
    logic [HASH_W-1:0] r_acc;
    logic [SLOT_W-1:0] r_rd_addr;
    logic [WIN_W-1:0]  r_issue_left;
    logic [WIN_W-1:0]  r_acc_left;
    logic              r_rd_vld;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_fp;
    logic              r_out_fp_valid;
    logic              r_out_last;

    logic              in_acc;
    logic              out_free;
    logic              cfg_wr;
    logic [WIN_W-1:0]  cfg_win;
    logic [SLOT_W-1:0] n_slot;
    logic [SEEN_W-1:0] n_seen;
    logic [SLOT_W-1:0] n_start;
    logic [SUM_W-1:0]  start_sum;
    logic              close_full;
    logic              rd_en;
    logic [HASH_W-1:0] rd_data;
    logic [HASH_W-1:0] comb_step;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // config port: single register, clamped to the supported window range
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_WINDOW);

    always_comb begin
        cfg_win = pwdata[WIN_W-1:0];
        if (cfg_win < WIN_W'(WINDOW_MIN)) begin
            cfg_win = WIN_W'(WINDOW_MIN);
        end else if (SUM_W'(cfg_win) > SUM_W'(MAX_WINDOW)) begin
            cfg_win = WIN_W'(MAX_WINDOW);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2:2] == REG_WINDOW) begin
            prdata = {{(32 - WIN_W){1'b0}}, r_window};
        end
    end

    // ring pointer, word count and oldest slot of the window after a word push
    always_comb begin
        n_slot = (r_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : r_slot + 1'b1;
        n_seen = (r_seen == SEEN_W'(MAX_WINDOW)) ? r_seen : r_seen + 1'b1;
        close_full = (SUM_W'(n_seen) >= SUM_W'(r_window));
        start_sum = SUM_W'(n_slot) + SUM_W'(MAX_WINDOW) - SUM_W'(r_window);
        if (start_sum >= SUM_W'(MAX_WINDOW)) begin
            start_sum = start_sum - SUM_W'(MAX_WINDOW);
        end
        n_start = start_sum[SLOT_W-1:0];
    end

    assign rd_en     = (r_state == S_COMB) && (r_issue_left != '0);
    assign comb_step = fnv_step(r_acc, rd_data);

    wsf_ring #(
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_CLOSE),
        .i_wr_addr (r_slot),
        .i_wr_data (r_word_hash),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_window       <= WIN_W'(WINDOW_RESET);
            r_word_hash    <= FNV_BASIS;
            r_in_word      <= 1'b0;
            r_slot         <= '0;
            r_seen         <= '0;
            r_last         <= 1'b0;
            r_fp_valid     <= 1'b0;
            r_issue_left   <= '0;
            r_acc_left     <= '0;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_window <= cfg_win;
            end
            r_rd_vld <= rd_en;
            // in S_EMIT the output register is reloaded below instead
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last <= i_end_of_text;
                        if (is_separator(i_text_byte)) begin
                            if (r_in_word) begin
                                r_state <= S_CLOSE;
                            end else if (i_end_of_text) begin
                                // end marker with no window hash
                                r_fp_valid <= 1'b0;
                                r_state    <= S_EMIT;
                            end
                        end else begin
                            r_word_hash <= fnv_step(r_word_hash, HASH_W'(i_text_byte));
                            r_in_word   <= 1'b1;
                            if (i_end_of_text) begin
                                r_state <= S_CLOSE;
                            end
                        end
                    end
                end
                S_CLOSE: begin
                    // ring write happens this cycle at r_slot
                    r_slot      <= n_slot;
                    r_seen      <= n_seen;
                    r_word_hash <= FNV_BASIS;
                    r_in_word   <= 1'b0;
                    r_fp_valid  <= 1'b0;
                    if (close_full) begin
                        r_acc        <= FNV_BASIS;
                        r_rd_addr    <= n_start;
                        r_issue_left <= r_window;
                        r_acc_left   <= r_window;
                        r_state      <= S_COMB;
                    end else if (r_last) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_COMB: begin
                    if (rd_en) begin
                        r_issue_left <= r_issue_left - 1'b1;
                        r_rd_addr    <= (r_rd_addr == SLOT_W'(MAX_WINDOW - 1)) ?
                                        '0 : r_rd_addr + 1'b1;
                    end
                    if (r_rd_vld) begin
                        r_acc      <= comb_step;
                        r_acc_left <= r_acc_left - 1'b1;
                        if (r_acc_left == WIN_W'(1)) begin
                            r_fp_valid <= 1'b1;
                            r_state    <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_fp       <= r_fp_valid ? r_acc : '0;
                        r_out_fp_valid <= r_fp_valid;
                        r_out_last     <= r_last;
                        r_state        <= S_IDLE;
                        if (r_last) begin
                            // next byte starts a new text
                            r_slot <= '0;
                            r_seen <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_fingerprint       = r_out_fp;
    assign o_fingerprint_valid = r_out_fp_valid;
    assign o_last_result       = r_out_last;

`ifndef SYNTHESIS
    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_end_of_text |=> r_state != S_IDLE)
        else $error("end-of-text request did not start a result");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_seen) <= SUM_W'(MAX_WINDOW))
        else $error("word count above ring depth");

    a_window_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window >= WIN_W'(WINDOW_MIN) && SUM_W'(r_window) <= SUM_W'(MAX_WINDOW))
        else $error("window size out of range");

    a_reads_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue_left <= r_acc_left)
        else $error("combine consumed more words than were read");

    a_mid_text_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_out_fp_valid)
        else $error("mid-text result without a fingerprint");
`endif

endmodule
